// ----- hw/rtl/bct_pkg.sv -----
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types, constants and BCD digit helpers for the mm:ss countdown timer.
// ----------------------------------------------------------------------------
package bct_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTickDivider  = 4'd0,
    CfgLockoutTicks = 4'd1
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned DivW     = 8;
  localparam int unsigned LockW    = 6;

  localparam logic [DivW-1:0]  TickDividerRst  = 8'd200;
  localparam logic [LockW-1:0] LockoutTicksRst = 6'd50;

  // Digit limits
  localparam logic [2:0] SecTensMax = 3'd5;
  localparam logic [3:0] DigitMax   = 4'd9;

  // One tick: three button levels
  typedef struct packed {
    logic up_pressed;
    logic down_pressed;
    logic start_pressed;
  } bct_in_t;

  // Displayed time and mode after a tick
  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [3:0] min_tens;
    logic       running;
  } bct_out_t;

  // Four BCD digits of mm:ss
  typedef struct packed {
    logic [3:0] sec_ones;
    logic [2:0] sec_tens;
    logic [3:0] min_ones;
    logic [3:0] min_tens;
  } bct_time_t;

  function automatic logic time_is_zero(bct_time_t t);
    return (t.sec_ones == 4'd0) && (t.sec_tens == 3'd0) &&
           (t.min_ones == 4'd0) && (t.min_tens == 4'd0);
  endfunction

  // Plus ten seconds with carry, holding once the time is 99:50 or more
  function automatic bct_time_t add_ten(bct_time_t t);
    bct_time_t r;
    r = t;
    if (!(t.min_tens >= DigitMax && t.min_ones >= DigitMax &&
          t.sec_tens >= SecTensMax)) begin
      if (t.sec_tens < SecTensMax) begin
        r.sec_tens = t.sec_tens + 3'd1;
      end else begin
        r.sec_tens = 3'd0;
        if (t.min_ones < DigitMax) begin
          r.min_ones = t.min_ones + 4'd1;
        end else begin
          r.min_ones = 4'd0;
          r.min_tens = t.min_tens + 4'd1;
        end
      end
    end
    return r;
  endfunction

  // Minus ten seconds with borrow; below ten seconds the time clears
  function automatic bct_time_t sub_ten(bct_time_t t);
    bct_time_t r;
    r = t;
    if (t.sec_tens != 3'd0) begin
      r.sec_tens = t.sec_tens - 3'd1;
    end else if (t.min_ones != 4'd0) begin
      r.min_ones = t.min_ones - 4'd1;
      r.sec_tens = SecTensMax;
    end else if (t.min_tens != 4'd0) begin
      r.min_tens = t.min_tens - 4'd1;
      r.min_ones = DigitMax;
      r.sec_tens = SecTensMax;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Minus one second with borrow, holding at 00:00
  function automatic bct_time_t sub_one(bct_time_t t);
    bct_time_t r;
    r = t;
    if (!time_is_zero(t)) begin
      if (t.sec_ones != 4'd0) begin
        r.sec_ones = t.sec_ones - 4'd1;
      end else begin
        r.sec_ones = DigitMax;
        if (t.sec_tens != 3'd0) begin
          r.sec_tens = t.sec_tens - 3'd1;
        end else begin
          r.sec_tens = SecTensMax;
          if (t.min_ones != 4'd0) begin
            r.min_ones = t.min_ones - 4'd1;
          end else begin
            r.min_ones = DigitMax;
            r.min_tens = t.min_tens - 4'd1;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bcd_countdown_timer.sv -----
// ----------------------------------------------------------------------------
// bcd_countdown_timer
// Four-digit BCD mm:ss countdown timer driven by one tick per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one tick with the up, down and start button
// levels; each tick produces exactly one result transaction with the four
// digits and the run flag as they stand after that tick. A tick is taken
// every clock cycle: the whole update is one pass of logic from the state
// registers into a two-entry output buffer (output register plus skid), so
// input stays ready while one result waits downstream and stalls only when
// both entries are full. Configuration (tick divider, lockout length) has
// an always-ready port; users must write it only while the block is idle.
// ----------------------------------------------------------------------------
module bcd_countdown_timer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Tick input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bct_pkg::bct_in_t                in_data_i,
  // Result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bct_pkg::bct_out_t               out_data_o,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bct_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bct_pkg::CfgDataW-1:0]    cfg_data_i
);

  // Configuration registers
  logic [bct_pkg::DivW-1:0]  div_q;
  logic [bct_pkg::LockW-1:0] lock_len_q;

  // Timer state
  bct_pkg::bct_time_t        time_q, time_d;
  logic                      run_q, run_d;
  logic [bct_pkg::DivW-1:0]  tick_cnt_q, tick_cnt_d;
  logic [bct_pkg::LockW-1:0] up_lock_q, up_lock_d;
  logic [bct_pkg::LockW-1:0] dn_lock_q, dn_lock_d;

  // Output buffer
  logic                      out_valid_q, out_valid_d;
  logic                      skid_valid_q, skid_valid_d;
  bct_pkg::bct_out_t         out_q, out_d;
  bct_pkg::bct_out_t         skid_q, skid_d;
  bct_pkg::bct_out_t         res;

  logic push, pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q      <= bct_pkg::TickDividerRst;
      lock_len_q <= bct_pkg::LockoutTicksRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bct_pkg::CfgTickDivider:  div_q      <= cfg_data_i[bct_pkg::DivW-1:0];
        bct_pkg::CfgLockoutTicks: lock_len_q <= cfg_data_i[bct_pkg::LockW-1:0];
        default: ;
      endcase
    end
  end

  // One tick of the timer
  always_comb begin
    logic                       up_free;
    logic                       dn_free;
    logic [bct_pkg::DivW:0]     tick_next;
    bct_pkg::bct_time_t         t;

    up_free   = (up_lock_q == '0);
    dn_free   = (dn_lock_q == '0);
    up_lock_d = up_free ? up_lock_q : up_lock_q - bct_pkg::LockW'(1);
    dn_lock_d = dn_free ? dn_lock_q : dn_lock_q - bct_pkg::LockW'(1);
    t         = time_q;

    // Set-mode buttons: up first, then down
    if (!run_q) begin
      if (up_free && in_data_i.up_pressed) begin
        t         = bct_pkg::add_ten(t);
        up_lock_d = lock_len_q;
      end
      if (dn_free && in_data_i.down_pressed) begin
        t         = bct_pkg::sub_ten(t);
        dn_lock_d = lock_len_q;
      end
    end

    run_d      = run_q || in_data_i.start_pressed;
    tick_cnt_d = tick_cnt_q;
    tick_next  = {1'b0, tick_cnt_q} + (bct_pkg::DivW + 1)'(1);

    // Countdown; a zero divider acts as one
    if (run_d) begin
      if (tick_next >= {1'b0, div_q}) begin
        tick_cnt_d = '0;
        t          = bct_pkg::sub_one(t);
      end else begin
        tick_cnt_d = tick_next[bct_pkg::DivW-1:0];
      end
      if (bct_pkg::time_is_zero(t)) begin
        run_d      = 1'b0;
        tick_cnt_d = '0;
      end
    end

    time_d       = t;
    res.sec_ones = t.sec_ones;
    res.sec_tens = t.sec_tens;
    res.min_ones = t.min_ones;
    res.min_tens = t.min_tens;
    res.running  = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q     <= '0;
      run_q      <= 1'b0;
      tick_cnt_q <= '0;
      up_lock_q  <= '0;
      dn_lock_q  <= '0;
    end else if (push) begin
      time_q     <= time_d;
      run_q      <= run_d;
      tick_cnt_q <= tick_cnt_d;
      up_lock_q  <= up_lock_d;
      dn_lock_q  <= dn_lock_d;
    end
  end

  // Output register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = push;
      end
    end else if (!out_valid_q) begin
      out_d       = res;
      out_valid_d = push;
    end else if (push) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef SYNTHESIS
  // Skid entry is only ever filled behind a held output entry
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output entry");

  // A tick accepted against a stalled full output lands in the skid entry
  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("stalled result was dropped");

  // Run mode never reports a time of 00:00
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> !bct_pkg::time_is_zero(time_q))
    else $error("running at 00:00");

  // Digits stay decimal
  a_digits_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.sec_ones <= bct_pkg::DigitMax) && (time_q.sec_tens <= bct_pkg::SecTensMax) &&
    (time_q.min_ones <= bct_pkg::DigitMax) && (time_q.min_tens <= bct_pkg::DigitMax))
    else $error("digit out of BCD range");
`endif

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the mm:ss BCD countdown timer.
// ----------------------------------------------------------------------------
// Ticks go in over a valid/ready channel in random bursts and results are
// drained with a stall pattern of their own. A seconds-based predictor tracks
// the timer, the lockouts and the divider phase, and every result transaction
// is checked field by field against the oldest predicted display. Directed
// tests cover reset settings, zero lockout and divider, divider changes while
// running and the 99:50 / 00:00 limits; random sessions follow.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned RandomTicks   = 60;
  localparam int unsigned MaxSecs       = 5999;  // 99:59
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned TimeoutCycles = 2000000;

  typedef enum logic [1:0] {
    RdyAlways,
    RdyMostly,
    RdySparse,
    RdyPulsed
  } ready_mode_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  bct_pkg::bct_in_t             in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  bct_pkg::bct_out_t            out_data_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [bct_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [bct_pkg::CfgDataW-1:0] cfg_data_i;

  // Predicted timer state: time kept as total seconds
  int unsigned     pred_secs;
  int unsigned     pred_sub_count;
  int unsigned     pred_up_hold;
  int unsigned     pred_dn_hold;
  logic            pred_running;
  logic [bct_pkg::DivW-1:0]  cfg_divider;
  logic [bct_pkg::LockW-1:0] cfg_lockout;

  bct_pkg::bct_out_t display_q[$];
  int unsigned tick_total;
  int unsigned burst_left;
  int unsigned mismatch_count;
  int unsigned random_stop;

  bcd_countdown_timer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("[bcd_countdown_timer] ERROR");
    $finish;
  end

  // Advance the predicted timer by one tick and return the expected display
  function automatic bct_pkg::bct_out_t advance_timer(bct_pkg::bct_in_t t);
    bct_pkg::bct_out_t d;
    logic        up_free;
    logic        dn_free;
    int unsigned mm;
    int unsigned ss;
    up_free = (pred_up_hold == 0);
    dn_free = (pred_dn_hold == 0);
    if (!up_free) pred_up_hold--;
    if (!dn_free) pred_dn_hold--;
    // buttons only act in set mode, up before down
    if (!pred_running) begin
      if (up_free && t.up_pressed) begin
        if (pred_secs + 10 <= MaxSecs) pred_secs += 10;
        pred_up_hold = cfg_lockout;
      end
      if (dn_free && t.down_pressed) begin
        pred_secs = (pred_secs >= 10) ? pred_secs - 10 : 0;
        pred_dn_hold = cfg_lockout;
      end
    end
    if (t.start_pressed) pred_running = 1'b1;
    // countdown; a zero divider acts as one
    if (pred_running) begin
      if (pred_sub_count + 1 >= cfg_divider) begin
        pred_sub_count = 0;
        if (pred_secs != 0) pred_secs--;
      end else begin
        pred_sub_count++;
      end
      if (pred_secs == 0) begin
        pred_running = 1'b0;
        pred_sub_count = 0;
      end
    end
    mm = pred_secs / 60;
    ss = pred_secs % 60;
    d.sec_ones = 4'(ss % 10);
    d.sec_tens = 3'(ss / 10);
    d.min_ones = 4'(mm % 10);
    d.min_tens = 4'(mm / 10);
    d.running  = pred_running;
    return d;
  endfunction

  function automatic bct_pkg::bct_in_t press(logic up, logic down, logic start);
    bct_pkg::bct_in_t b;
    b.up_pressed    = up;
    b.down_pressed  = down;
    b.start_pressed = start;
    return b;
  endfunction

  // Send one tick; bursts of random length separated by random gaps
  task automatic send_tick(input bct_pkg::bct_in_t t);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    display_q.push_back(advance_timer(t));
    tick_total++;
    burst_left--;
  endtask

  // Stop sending and wait for every predicted display to come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (display_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input bct_pkg::cfg_reg_e idx,
                           input logic [bct_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bct_pkg::CfgTickDivider:  cfg_divider = val[bct_pkg::DivW-1:0];
      bct_pkg::CfgLockoutTicks: cfg_lockout = val[bct_pkg::LockW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [bct_pkg::DivW-1:0] div,
                            input logic [bct_pkg::LockW-1:0] lock);
    wait_idle();
    cfg_write(bct_pkg::CfgTickDivider, bct_pkg::CfgDataW'(div));
    cfg_write(bct_pkg::CfgLockoutTicks, bct_pkg::CfgDataW'(lock));
    cfg_valid_i <= 1'b0;
  endtask

  // Idle ticks until the countdown is over and both buttons are free
  task automatic settle_timer();
    while (pred_running || pred_up_hold != 0 || pred_dn_hold != 0)
      send_tick(press(1'b0, 1'b0, 1'b0));
  endtask

  // Reset settings: start and down at 00:00, lockout blocking, run-mode presses
  task automatic test_power_on();
    send_tick(press(1'b0, 1'b0, 1'b0));
    send_tick(press(1'b0, 1'b0, 1'b1));  // enters and leaves run mode at once
    send_tick(press(1'b0, 1'b1, 1'b0));  // clamps at 00:00, still locks
    send_tick(press(1'b1, 1'b0, 1'b0));
    send_tick(press(1'b1, 1'b1, 1'b0));  // both buttons locked
    send_tick(press(1'b0, 1'b0, 1'b1));
    send_tick(press(1'b1, 1'b1, 1'b1));  // ignored while running
  endtask

  // Zero lockout and zero divider
  task automatic test_zero_settings();
    set_config('0, '0);
    settle_timer();
    repeat (3) send_tick(press(1'b1, 1'b0, 1'b0));
    send_tick(press(1'b1, 1'b1, 1'b0));  // up then down in one tick
    send_tick(press(1'b0, 1'b1, 1'b0));
    send_tick(press(1'b0, 1'b0, 1'b1));  // start tick already takes a second
    send_tick(press(1'b0, 1'b0, 1'b1));  // start while running
    send_tick(press(1'b1, 1'b0, 1'b0));
    settle_timer();
  endtask

  // Divider phase across start and across divider changes mid-run
  task automatic test_divider_phase();
    set_config(8'd3, 6'd1);
    send_tick(press(1'b1, 1'b0, 1'b0));
    send_tick(press(1'b1, 1'b0, 1'b0));  // locked for one tick
    send_tick(press(1'b1, 1'b0, 1'b0));
    send_tick(press(1'b0, 1'b0, 1'b1));
    repeat (2) send_tick(press(1'b0, 1'b0, 1'b0));
    send_tick(press(1'b0, 1'b0, 1'b1));
    set_config('1, '1);
    repeat (2) send_tick(press(1'b0, 1'b0, 1'b0));
    // count already past the new divider
    set_config(8'd2, 6'd1);
    send_tick(press(1'b0, 1'b0, 1'b0));
    settle_timer();
  endtask

  // Climb to the 99:50 ceiling and back down to the 00:00 floor
  task automatic test_saturation();
    set_config(8'd1, '0);
    settle_timer();
    repeat (604) send_tick(press(1'b1, 1'b0, 1'b0));
    send_tick(press(1'b1, 1'b1, 1'b0));
    repeat (604) send_tick(press(1'b0, 1'b1, 1'b0));
  endtask

  // One random setting, then a set phase aiming at a time and a countdown
  task automatic timer_session();
    logic [bct_pkg::DivW-1:0]  div;
    logic [bct_pkg::LockW-1:0] lock;
    int unsigned      eff;
    int unsigned      goal;
    int unsigned      n;
    case ($urandom_range(0, 9))
      0:       div = '0;
      1:       div = '1;
      2:       div = bct_pkg::DivW'($urandom_range(5, 254));
      default: div = bct_pkg::DivW'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 9))
      0:       lock = '0;
      1:       lock = '1;
      2:       lock = bct_pkg::LockW'($urandom_range(5, 62));
      default: lock = bct_pkg::LockW'($urandom_range(1, 4));
    endcase
    set_config(div, lock);
    if ($urandom_range(0, 5) == 0) begin
      // plain noise on all three buttons
      repeat ($urandom_range(20, 60)) send_tick(bct_pkg::bct_in_t'(3'($urandom)));
    end else begin
      eff  = (div == 0) ? 1 : div;
      goal = 10 * $urandom_range(1, (eff <= 2) ? 20 : (eff <= 6) ? 8 : 2);
      n = 0;
      while (!pred_running && n < 300 && tick_total < random_stop) begin
        send_tick(press((pred_secs < goal) ? 1'($urandom_range(0, 1))
                                           : ($urandom_range(0, 7) == 0),
                        $urandom_range(0, 5) == 0,
                        (pred_secs >= goal) ? ($urandom_range(0, 3) == 0)
                                            : ($urandom_range(0, 39) == 0)));
        n++;
      end
      n = 0;
      while (pred_running && n < 600 && tick_total < random_stop) begin
        send_tick(press($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                        $urandom_range(0, 7) == 0));
        n++;
      end
    end
  endtask

  task automatic test_random();
    random_stop = tick_total + RandomTicks;
    while (tick_total < random_stop) timer_session();
  endtask

  // Result side stall pattern
  initial begin : ready_pattern
    ready_mode_e mode;
    int unsigned left;
    out_ready_i <= 1'b0;
    mode = RdyAlways;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        left = $urandom_range(16, 120);
      end
      left--;
      case (mode)
        RdyAlways: out_ready_i <= 1'b1;
        RdyMostly: out_ready_i <= ($urandom_range(0, 3) != 0);
        RdySparse: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:   out_ready_i <= left[2];
      endcase
    end
  end

  // Compare each result transaction with the oldest predicted display
  always @(posedge clk_i) begin : check_display
    bct_pkg::bct_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (display_q.size() == 0) begin
        $error("result with no tick pending: %p", out_data_o);
        mismatch_count++;
      end else begin
        want = display_q.pop_front();
        if (out_data_o.sec_ones !== want.sec_ones) begin
          $error("sec_ones: expected %0d, got %0d", want.sec_ones, out_data_o.sec_ones);
          mismatch_count++;
        end
        if (out_data_o.sec_tens !== want.sec_tens) begin
          $error("sec_tens: expected %0d, got %0d", want.sec_tens, out_data_o.sec_tens);
          mismatch_count++;
        end
        if (out_data_o.min_ones !== want.min_ones) begin
          $error("min_ones: expected %0d, got %0d", want.min_ones, out_data_o.min_ones);
          mismatch_count++;
        end
        if (out_data_o.min_tens !== want.min_tens) begin
          $error("min_tens: expected %0d, got %0d", want.min_tens, out_data_o.min_tens);
          mismatch_count++;
        end
        if (out_data_o.running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, out_data_o.running);
          mismatch_count++;
        end
      end
    end
  end

  // Test sequence
  initial begin : run_tests
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    pred_secs      = 0;
    pred_sub_count = 0;
    pred_up_hold   = 0;
    pred_dn_hold   = 0;
    pred_running   = 1'b0;
    cfg_divider    = bct_pkg::TickDividerRst;
    cfg_lockout    = bct_pkg::LockoutTicksRst;
    tick_total     = 0;
    burst_left     = 0;
    mismatch_count = 0;
    random_stop    = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_power_on();
    test_zero_settings();
    test_divider_phase();
    test_saturation();
    test_random();

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[bcd_countdown_timer] OK");
    end else begin
      $display("[bcd_countdown_timer] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bct_pkg.sv
hw/rtl/bcd_countdown_timer.sv
test/tb.sv
